// File: rtl/ots_pkg.sv
// Shared types, constants and a helper function for the overlap-add time stretcher.
package ots_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int POS_W      = 11;
    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 56;
    localparam int FRAC_W     = 16;
    localparam int WEIGHT_W   = FRAC_W + 1;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W + 1;
    localparam int FADE_W     = 10;
    localparam int STEP_W     = 17;
    localparam int PADDR_W    = 5;

    localparam logic [POS_W-1:0]  WIN_RESET   = 11'd960;
    localparam logic [POS_W-1:0]  ISHIFT_RESET = 11'd768;
    localparam logic [POS_W-1:0]  OSHIFT_RESET = 11'd768;
    localparam logic [FADE_W-1:0] FADE_RESET  = 10'd192;
    localparam logic [STEP_W-1:0] STEP_RESET  = 17'd343;

    localparam logic [2:0] REG_WINDOW_SIZE  = 3'd0;
    localparam logic [2:0] REG_INPUT_SHIFT  = 3'd1;
    localparam logic [2:0] REG_OUTPUT_SHIFT = 3'd2;
    localparam logic [2:0] REG_FADE_LEN     = 3'd3;
    localparam logic [2:0] REG_FADE_STEP    = 3'd4;

    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_PULL    = 2'd1;
    localparam logic [1:0] CMD_FLUSH   = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_BUSY   = 2'd1;
    localparam logic [1:0] STS_NOOUT  = 2'd2;
    localparam logic [1:0] STS_ENDED  = 2'd3;

    typedef enum logic [1:0] {
        PH_FILL  = 2'd0,
        PH_EMIT  = 2'd1,
        PH_DRAIN = 2'd2,
        PH_END   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ZPAD,
        S_COMB,
        S_SETTLE,
        S_OZERO,
        S_RD,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [POS_W-1:0]  win;
        logic [POS_W-1:0]  ishift;
        logic [POS_W-1:0]  oshift;
        logic [FADE_W-1:0] fade;
        logic [STEP_W-1:0] step;
    } cfg_t;

    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic signed [ACC_W-1:0] data;
    } acc_wr_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                clip;
    } conv_t;

    function automatic conv_t acc_to_sample(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0]        mag;
        logic [ACC_W-FRAC_W-1:0] sh;
        conv_t                   r;
        mag = a[ACC_W-1] ? (~a + 1'b1) : a;
        sh  = mag[ACC_W-1:FRAC_W];
        r.clip = 1'b0;
        if (a[ACC_W-1]) begin
            if (sh > (ACC_W-FRAC_W)'(41'h0_8000_0000)) begin
                r.clip   = 1'b1;
                r.sample = 32'h8000_0000;
            end else begin
                r.sample = ~sh[SAMPLE_W-1:0] + 1'b1;
            end
        end else begin
            if (sh > (ACC_W-FRAC_W)'(41'h0_7FFF_FFFF)) begin
                r.clip   = 1'b1;
                r.sample = 32'h7FFF_FFFF;
            end else begin
                r.sample = sh[SAMPLE_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/ots_cfg.sv
// Configuration register file with APB access and clamped working values.
module ots_cfg import ots_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [POS_W-1:0]  win_reg, ishift_reg, oshift_reg;
    logic [FADE_W-1:0] fade_reg;
    logic [STEP_W-1:0] step_reg;
    logic [2:0]        idx;
    logic              wr;
    logic [POS_W-1:0]  w, half;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= WIN_RESET;
            ishift_reg <= ISHIFT_RESET;
            oshift_reg <= OSHIFT_RESET;
            fade_reg   <= FADE_RESET;
            step_reg   <= STEP_RESET;
        end else if (wr) begin
            case (idx)
                REG_WINDOW_SIZE:  win_reg    <= pwdata[POS_W-1:0];
                REG_INPUT_SHIFT:  ishift_reg <= pwdata[POS_W-1:0];
                REG_OUTPUT_SHIFT: oshift_reg <= pwdata[POS_W-1:0];
                REG_FADE_LEN:     fade_reg   <= pwdata[FADE_W-1:0];
                REG_FADE_STEP:    step_reg   <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WINDOW_SIZE:  prdata = 32'(win_reg);
            REG_INPUT_SHIFT:  prdata = 32'(ishift_reg);
            REG_OUTPUT_SHIFT: prdata = 32'(oshift_reg);
            REG_FADE_LEN:     prdata = 32'(fade_reg);
            REG_FADE_STEP:    prdata = 32'(step_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (win_reg < 11'd2) w = 11'd2;
        else if (win_reg > POS_W'(MAX_WINDOW)) w = POS_W'(MAX_WINDOW);
        else w = win_reg;
        half = w >> 1;
        cfg.win = w;
        if (ishift_reg < 11'd1) cfg.ishift = 11'd1;
        else if (ishift_reg > w) cfg.ishift = w;
        else cfg.ishift = ishift_reg;
        if (oshift_reg < 11'd1) cfg.oshift = 11'd1;
        else if (oshift_reg > w) cfg.oshift = w;
        else cfg.oshift = oshift_reg;
        cfg.fade = (POS_W'(fade_reg) > half) ? half[FADE_W-1:0] : fade_reg;
        cfg.step = step_reg;
    end

endmodule

// File: rtl/ots_comb_dp.sv
// Window combine datapath: ramp weight, multiply, saturating accumulate.
module ots_comb_dp import ots_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    issue,
    input  logic [POS_W-1:0]        idx,
    input  logic [ADDR_W-1:0]       acc_addr,
    input  cfg_t                    cfg,
    input  logic signed [SAMPLE_W-1:0] in_rdata,
    input  logic signed [ACC_W-1:0] acc_rdata,
    output acc_wr_t                 wr,
    output logic                    busy
);

    logic                    s1_valid_reg, s2_valid_reg;
    logic [WEIGHT_W-1:0]     s1_wt_reg, wt_next;
    logic [ADDR_W-1:0]       s1_addr_reg, s2_addr_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [ACC_W-1:0] s2_acc_reg;
    logic                    lo, hi;
    logic [POS_W-1:0]        k;
    logic [FADE_W+STEP_W-1:0] rp;
    logic signed [ACC_W:0]   sum;

    always_comb begin
        lo = (cfg.fade > 10'd1) && (idx < POS_W'(cfg.fade));
        hi = (cfg.fade > 10'd1) && (idx >= cfg.win - POS_W'(cfg.fade));
        k  = lo ? idx : (cfg.win - 11'd1 - idx);
        rp = k[FADE_W-1:0] * cfg.step;
        if (lo || hi) begin
            wt_next = (rp > (FADE_W+STEP_W)'(1 << FRAC_W)) ? WEIGHT_W'(1 << FRAC_W)
                                                          : rp[WEIGHT_W-1:0];
        end else begin
            wt_next = WEIGHT_W'(1 << FRAC_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
        s1_wt_reg   <= wt_next;
        s1_addr_reg <= acc_addr;
        s2_prod_reg <= in_rdata * $signed({1'b0, s1_wt_reg});
        s2_acc_reg  <= acc_rdata;
        s2_addr_reg <= s1_addr_reg;
    end

    always_comb begin
        sum     = (ACC_W+1)'(s2_acc_reg) + (ACC_W+1)'(s2_prod_reg);
        wr.en   = s2_valid_reg;
        wr.addr = s2_addr_reg;
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            wr.data = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            wr.data = sum[ACC_W-1:0];
        end
    end

    assign busy = s1_valid_reg | s2_valid_reg;

endmodule

// File: rtl/overlap_add_time_stretch.sv
// Top level of the overlap-add time stretcher: sequencer and both sample stores.
//
//  channel   direction  ports
//  s_        in         s_valid s_ready s_command s_sample
//  m_        out        m_valid m_ready m_status m_out_sample m_clipped m_last_sample
//  apb       in/out     psel penable pwrite paddr pwdata prdata pready
//
// A push that fills the window runs the combine over the whole window; the
// output_shift accumulator entries freed when the output advances are zeroed.
// A flush in the fill phase zeroes the rest of the input window first, one entry per cycle.
// After reset and after each restart a clearing pass zeroes all 1024 entries of both memories.
// A new request is taken while the previous result waits on m_ready.
module overlap_add_time_stretch import ots_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic signed [SAMPLE_W-1:0] m_out_sample,
    output logic                       m_clipped,
    output logic                       m_last_sample,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    cfg_t cfg;

    fsm_t              state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  fill_reg, fill_next, emit_reg, emit_next, cnt_reg, cnt_next;
    logic [ADDR_W-1:0] ibase_reg, ibase_next, obase_reg, obase_next;
    logic              flush_reg, flush_next, rsp_reg, rsp_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [SAMPLE_W-1:0] res_sample_reg, res_sample_next;
    logic              res_clip_reg, res_clip_next, res_last_reg, res_last_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg;
    logic [SAMPLE_W-1:0] m_sample_reg;
    logic              m_clip_reg, m_last_reg, m_load;

    logic signed [SAMPLE_W-1:0] in_store [MAX_WINDOW];
    logic signed [ACC_W-1:0] acc_store [MAX_WINDOW];
    logic                    in_we;
    logic [ADDR_W-1:0]       in_waddr, in_raddr, acc_raddr;
    logic signed [SAMPLE_W-1:0] in_wdata, in_rdata_reg;
    logic signed [ACC_W-1:0] acc_rdata_reg;
    acc_wr_t                 dp_wr, acc_wr;
    logic                    dp_issue, dp_busy;
    conv_t                   conv;

    ots_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    ots_comb_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .issue(dp_issue), .idx(cnt_reg),
        .acc_addr(acc_raddr), .cfg(cfg), .in_rdata(in_rdata_reg),
        .acc_rdata(acc_rdata_reg), .wr(dp_wr), .busy(dp_busy)
    );

    always_ff @(posedge aclk) begin
        if (in_we) begin
            in_store[in_waddr] <= in_wdata;
        end
        in_rdata_reg <= in_store[in_raddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_wr.en) begin
            acc_store[acc_wr.addr] <= acc_wr.data;
        end
        acc_rdata_reg <= acc_store[acc_raddr];
    end

    assign conv = acc_to_sample(acc_rdata_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            phase_reg   <= PH_FILL;
            fill_reg    <= WIN_RESET >> 1;
            emit_reg    <= WIN_RESET >> 1;
            cnt_reg     <= '0;
            ibase_reg   <= '0;
            obase_reg   <= '0;
            flush_reg   <= 1'b0;
            rsp_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            emit_reg    <= emit_next;
            cnt_reg     <= cnt_next;
            ibase_reg   <= ibase_next;
            obase_reg   <= obase_next;
            flush_reg   <= flush_next;
            rsp_reg     <= rsp_next;
            m_valid_reg <= m_valid_next;
        end
        res_status_reg <= res_status_next;
        res_sample_reg <= res_sample_next;
        res_clip_reg   <= res_clip_next;
        res_last_reg   <= res_last_next;
        if (m_load) begin
            m_status_reg <= res_status_reg;
            m_sample_reg <= res_sample_reg;
            m_clip_reg   <= res_clip_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        fill_next       = fill_reg;
        emit_next       = emit_reg;
        cnt_next        = cnt_reg;
        ibase_next      = ibase_reg;
        obase_next      = obase_reg;
        flush_next      = flush_reg;
        rsp_next        = rsp_reg;
        res_status_next = res_status_reg;
        res_sample_next = res_sample_reg;
        res_clip_next   = res_clip_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_load          = 1'b0;
        s_ready         = 1'b0;
        in_we           = 1'b0;
        in_waddr        = ibase_reg + cnt_reg[ADDR_W-1:0];
        in_wdata        = '0;
        in_raddr        = ibase_reg + cnt_reg[ADDR_W-1:0];
        acc_raddr       = obase_reg + cnt_reg[ADDR_W-1:0];
        acc_wr          = dp_wr;
        dp_issue        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                acc_raddr = obase_reg + emit_reg[ADDR_W-1:0];
                if (s_valid) begin
                    res_status_next = STS_OK;
                    res_sample_next = '0;
                    res_clip_next   = 1'b0;
                    res_last_next   = 1'b0;
                    state_next      = S_DONE;
                    case (s_command)
                        CMD_PUSH: begin
                            if (phase_reg == PH_EMIT) begin
                                res_status_next = STS_BUSY;
                            end else if (phase_reg != PH_FILL) begin
                                res_status_next = STS_ENDED;
                            end else begin
                                in_we     = 1'b1;
                                in_waddr  = ibase_reg + fill_reg[ADDR_W-1:0];
                                in_wdata  = s_sample;
                                fill_next = fill_reg + 1'b1;
                                if (fill_reg + 1'b1 >= cfg.win) begin
                                    flush_next = 1'b0;
                                    cnt_next   = '0;
                                    state_next = S_COMB;
                                end
                            end
                        end
                        CMD_PULL: begin
                            case (phase_reg)
                                PH_FILL: res_status_next = STS_NOOUT;
                                PH_END:  res_status_next = STS_ENDED;
                                PH_EMIT: begin
                                    if (emit_reg >= cfg.oshift) begin
                                        res_status_next = STS_NOOUT;
                                        state_next      = S_SETTLE;
                                    end else begin
                                        state_next = S_RD;
                                    end
                                end
                                default: begin
                                    if (emit_reg >= fill_reg) begin
                                        phase_next      = PH_END;
                                        res_status_next = STS_ENDED;
                                    end else begin
                                        state_next = S_RD;
                                    end
                                end
                            endcase
                        end
                        CMD_FLUSH: begin
                            case (phase_reg)
                                PH_END: res_status_next = STS_ENDED;
                                PH_FILL: begin
                                    flush_next = 1'b1;
                                    if (fill_reg < cfg.win) begin
                                        cnt_next   = fill_reg;
                                        state_next = S_ZPAD;
                                    end else begin
                                        cnt_next   = '0;
                                        state_next = S_COMB;
                                    end
                                end
                                default: begin
                                    phase_next = (emit_reg >= fill_reg) ? PH_END : PH_DRAIN;
                                end
                            endcase
                        end
                        default: begin
                            fill_next  = cfg.win >> 1;
                            emit_next  = cfg.win >> 1;
                            ibase_next = '0;
                            obase_next = '0;
                            phase_next = PH_FILL;
                            cnt_next   = '0;
                            rsp_next   = 1'b1;
                            state_next = S_CLEAR;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                in_we       = 1'b1;
                in_waddr    = cnt_reg[ADDR_W-1:0];
                acc_wr.en   = 1'b1;
                acc_wr.addr = cnt_reg[ADDR_W-1:0];
                acc_wr.data = '0;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == POS_W'(MAX_WINDOW - 1)) begin
                    cnt_next   = '0;
                    rsp_next   = 1'b0;
                    state_next = rsp_reg ? S_DONE : S_IDLE;
                end
            end
            S_ZPAD: begin
                in_we    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 >= cfg.win) begin
                    cnt_next   = '0;
                    state_next = S_COMB;
                end
            end
            S_COMB: begin
                if (cnt_reg < cfg.win) begin
                    dp_issue = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end else if (!dp_busy) begin
                    if (flush_reg) begin
                        phase_next = (emit_reg >= fill_reg) ? PH_END : PH_DRAIN;
                        state_next = S_DONE;
                    end else begin
                        ibase_next = ibase_reg + cfg.ishift[ADDR_W-1:0];
                        fill_next  = fill_reg - cfg.ishift;
                        phase_next = PH_EMIT;
                        state_next = S_SETTLE;
                    end
                end
            end
            S_SETTLE: begin
                state_next = S_DONE;
                if (phase_reg == PH_EMIT && emit_reg >= cfg.oshift) begin
                    obase_next = obase_reg + cfg.oshift[ADDR_W-1:0];
                    emit_next  = emit_reg - cfg.oshift;
                    phase_next = PH_FILL;
                    cnt_next   = cfg.win - cfg.oshift;
                    state_next = S_OZERO;
                end
            end
            S_OZERO: begin
                acc_wr.en   = 1'b1;
                acc_wr.addr = obase_reg + cnt_reg[ADDR_W-1:0];
                acc_wr.data = '0;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 >= cfg.win) begin
                    state_next = S_DONE;
                end
            end
            S_RD: begin
                res_sample_next = conv.sample;
                res_clip_next   = conv.clip;
                emit_next       = emit_reg + 1'b1;
                if (phase_reg == PH_EMIT) begin
                    state_next = S_SETTLE;
                end else begin
                    state_next = S_DONE;
                    if (emit_reg + 1'b1 >= fill_reg) begin
                        phase_next    = PH_END;
                        res_last_next = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_load       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (state_reg != S_CLEAR && state_reg != S_OZERO && state_reg != S_COMB) begin
            acc_wr.en = 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_sample  = m_sample_reg;
    assign m_clipped     = m_clip_reg;
    assign m_last_sample = m_last_reg;

endmodule

// File: dv/overlap_add_time_stretch_tb.sv
// Self-checking testbench for the overlap-add time stretcher: directed and random requests.
`timescale 1ns / 100ps

module overlap_add_time_stretch_tb import ots_pkg::*; ();

    typedef struct {
        logic [1:0]  status;
        logic [31:0] smp;
        logic        clip;
        logic        last;
    } stretch_result_t;

    localparam longint ACC_HI = (64'sd1 <<< 55) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 55);
    localparam longint W_ONE  = 64'sd1 <<< FRAC_W;
    localparam int     SETTLE_CYCLES = 2200;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_command;
    logic signed [31:0] s_sample;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_status;
    logic signed [31:0] m_out_sample;
    logic              m_clipped;
    logic              m_last_sample;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    stretch_result_t   pending_results[$];
    int                error_count = 0;
    bit                throttle = 1'b1;
    int                ready_hold = 0;

    // Shadow copy of the registers and of the stretcher state.
    int unsigned       win_reg, ishift_reg, oshift_reg, fade_reg, step_reg;
    longint            in_win[MAX_WINDOW];
    longint            acc_mem[MAX_WINDOW];
    int unsigned       fill_pos, emit_pos, in_base, out_base;
    phase_t            cur_phase;

    overlap_add_time_stretch DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_sample(m_out_sample), .m_clipped(m_clipped), .m_last_sample(m_last_sample),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #80_000_000;
        $display("overlap_add_time_stretch_tb: errors");
        $finish;
    end

    function automatic int unsigned used_window();
        int unsigned w;
        w = win_reg;
        if (w < 2) w = 2;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        return w;
    endfunction

    function automatic int unsigned used_shift(int unsigned s);
        int unsigned w;
        w = used_window();
        if (s < 1) s = 1;
        if (s > w) s = w;
        return s;
    endfunction

    function automatic longint fade_weight(int unsigned k);
        longint w;
        w = longint'(k) * longint'(step_reg);
        return (w > W_ONE) ? W_ONE : w;
    endfunction

    function automatic void overlap_add();
        int unsigned w, f, o;
        longint wt, a;
        w = used_window();
        f = (fade_reg > w / 2) ? w / 2 : fade_reg;
        for (int unsigned i = 0; i < w; i++) begin
            wt = W_ONE;
            if (f > 1) begin
                if (i < f) wt = fade_weight(i);
                else if (i >= w - f) wt = fade_weight(w - 1 - i);
            end
            o = (out_base + i) % MAX_WINDOW;
            a = acc_mem[o] + in_win[(in_base + i) % MAX_WINDOW] * wt;
            if (a > ACC_HI) a = ACC_HI;
            if (a < ACC_LO) a = ACC_LO;
            acc_mem[o] = a;
        end
    endfunction

    function automatic void advance_output();
        int unsigned w, os;
        w = used_window();
        os = used_shift(oshift_reg);
        if (cur_phase != PH_EMIT || emit_pos < os) return;
        out_base = (out_base + os) % MAX_WINDOW;
        for (int unsigned j = w - os; j < w; j++) acc_mem[(out_base + j) % MAX_WINDOW] = 0;
        emit_pos -= os;
        cur_phase = PH_FILL;
    endfunction

    function automatic void read_output(ref stretch_result_t r);
        longint a, q;
        a = acc_mem[(out_base + emit_pos) % MAX_WINDOW];
        q = (a < 0) ? -((-a) >>> FRAC_W) : (a >>> FRAC_W);
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            r.clip = 1'b1;
        end
        if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            r.clip = 1'b1;
        end
        r.smp = q[31:0];
        emit_pos++;
    endfunction

    function automatic void clear_stores();
        foreach (in_win[i]) in_win[i] = 0;
        foreach (acc_mem[i]) acc_mem[i] = 0;
        fill_pos = used_window() / 2;
        emit_pos = fill_pos;
        in_base = 0;
        out_base = 0;
        cur_phase = PH_FILL;
    endfunction

    function automatic stretch_result_t predict_stretch(logic [1:0] cmd, logic signed [31:0] smp);
        stretch_result_t r;
        int unsigned w;
        r = '{STS_OK, 32'd0, 1'b0, 1'b0};
        w = used_window();
        case (cmd)
            CMD_PUSH: begin
                if (cur_phase == PH_EMIT) r.status = STS_BUSY;
                else if (cur_phase != PH_FILL) r.status = STS_ENDED;
                else begin
                    in_win[(in_base + fill_pos) % MAX_WINDOW] = longint'(smp);
                    fill_pos = (fill_pos + 1) & 11'h7FF;
                    if (fill_pos >= w) begin
                        overlap_add();
                        in_base = (in_base + used_shift(ishift_reg)) % MAX_WINDOW;
                        fill_pos -= used_shift(ishift_reg);
                        cur_phase = PH_EMIT;
                        advance_output();
                    end
                end
            end
            CMD_PULL: begin
                if (cur_phase == PH_FILL) r.status = STS_NOOUT;
                else if (cur_phase == PH_END) r.status = STS_ENDED;
                else if (cur_phase == PH_EMIT) begin
                    if (emit_pos >= used_shift(oshift_reg)) begin
                        advance_output();
                        r.status = STS_NOOUT;
                    end else begin
                        read_output(r);
                        advance_output();
                    end
                end else if (emit_pos >= fill_pos) begin
                    cur_phase = PH_END;
                    r.status = STS_ENDED;
                end else begin
                    read_output(r);
                    if (emit_pos >= fill_pos) begin
                        cur_phase = PH_END;
                        r.last = 1'b1;
                    end
                end
            end
            CMD_FLUSH: begin
                if (cur_phase == PH_END) r.status = STS_ENDED;
                else begin
                    if (cur_phase == PH_FILL) begin
                        for (int unsigned j = fill_pos; j < w; j++)
                            in_win[(in_base + j) % MAX_WINDOW] = 0;
                        overlap_add();
                        cur_phase = PH_DRAIN;
                    end else if (cur_phase == PH_EMIT) begin
                        cur_phase = PH_DRAIN;
                    end
                    if (cur_phase == PH_DRAIN && emit_pos >= fill_pos) cur_phase = PH_END;
                end
            end
            default: clear_stores();
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        stretch_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d", m_status);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    error_count++;
                end
                if (m_out_sample !== e.smp) begin
                    $error("out_sample: expected %0d, got %0d", $signed(e.smp), m_out_sample);
                    error_count++;
                end
                if (m_clipped !== e.clip) begin
                    $error("clipped: expected %0d, got %0d", e.clip, m_clipped);
                    error_count++;
                end
                if (m_last_sample !== e.last) begin
                    $error("last_sample: expected %0d, got %0d", e.last, m_last_sample);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!throttle) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_ready <= 1'b1;
                ready_hold <= $urandom_range(0, 20);
            end else if (r < 92) begin
                m_ready <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (!throttle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(logic [1:0] cmd, logic signed [31:0] smp);
        int gap;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_sample <= smp;
        pending_results.push_back(predict_stretch(cmd, smp));
        do @(posedge aclk); while (!s_ready);
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== value) begin
            $error("register %0d: expected %0d, got %0d", idx, value, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_WINDOW_SIZE:  win_reg = value;
            REG_INPUT_SHIFT:  ishift_reg = value;
            REG_OUTPUT_SHIFT: oshift_reg = value;
            REG_FADE_LEN:     fade_reg = value;
            default:          step_reg = value;
        endcase
    endtask

    task automatic set_config(int unsigned w, int unsigned is, int unsigned os,
                              int unsigned f, int unsigned st);
        write_reg(REG_WINDOW_SIZE, w);
        write_reg(REG_INPUT_SHIFT, is);
        write_reg(REG_OUTPUT_SHIFT, os);
        write_reg(REG_FADE_LEN, f);
        write_reg(REG_FADE_STEP, st);
    endtask

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_frame_cycle();
        set_config(8, 4, 8, 1, 65536);
        send_request(CMD_RESTART, 0);
        send_request(CMD_PULL, 0);
        send_request(CMD_PUSH, 32'sh7FFF_FFFF);
        send_request(CMD_PUSH, 32'sh8000_0000);
        send_request(CMD_PUSH, 32'sh7FFF_FFFF);
        send_request(CMD_PUSH, -32'sd1);
        send_request(CMD_PUSH, 32'sd5);
        repeat (4) send_request(CMD_PULL, 0);
        send_request(CMD_FLUSH, 0);
        send_request(CMD_FLUSH, 0);
        repeat (6) send_request(CMD_PULL, 0);
        send_request(CMD_PUSH, 32'sd1);
        send_request(CMD_FLUSH, 0);
        drain_results();
    endtask

    task automatic test_midstream_registers();
        set_config(16, 16, 16, 8, 9362);
        send_request(CMD_RESTART, 0);
        repeat (8) send_request(CMD_PUSH, pick_sample());
        repeat (3) send_request(CMD_PULL, 0);
        drain_results();
        write_reg(REG_OUTPUT_SHIFT, 4);
        send_request(CMD_PULL, 0);
        send_request(CMD_PULL, 0);
        repeat (4) send_request(CMD_PUSH, pick_sample());
        drain_results();
        write_reg(REG_WINDOW_SIZE, 6);
        send_request(CMD_PUSH, pick_sample());
        send_request(CMD_FLUSH, 0);
        send_request(CMD_PULL, 0);
        send_request(CMD_RESTART, 0);
        send_request(CMD_FLUSH, 0);
        drain_results();
    endtask

    task automatic test_default_stream();
        repeat (500) send_request(CMD_PUSH, pick_sample());
        repeat (300) send_request(CMD_PULL, 0);
        send_request(CMD_FLUSH, 0);
        drain_results();
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        case (cur_phase)
            PH_FILL: begin
                if (r < 86) send_request(CMD_PUSH, pick_sample());
                else if (r < 92) send_request(CMD_PULL, $urandom());
                else if (r < 97) send_request(CMD_FLUSH, $urandom());
                else send_request(CMD_RESTART, $urandom());
            end
            PH_EMIT: begin
                if (r < 86) send_request(CMD_PULL, 0);
                else if (r < 94) send_request(CMD_PUSH, pick_sample());
                else if (r < 98) send_request(CMD_FLUSH, 0);
                else send_request(CMD_RESTART, 0);
            end
            PH_DRAIN: begin
                if (r < 90) send_request(CMD_PULL, 0);
                else send_request(2'(r), $urandom());
            end
            default: begin
                if (r < 70) send_request(CMD_RESTART, 0);
                else send_request(2'(r), $urandom());
            end
        endcase
    endtask

    task automatic test_random_streams();
        int unsigned w, is, os;
        for (int p = 0; p < 12; p++) begin
            throttle = (p % 4) != 3;
            if (p == 11) w = 1024;
            else if (p % 5 == 4) w = $urandom_range(0, 1);
            else w = $urandom_range(2, 64);
            is = (w > 128) ? $urandom_range(w / 2, w) : $urandom_range(0, w + 2);
            os = $urandom_range(0, w + 2);
            if (p == 2) set_config(w, is, os, 0, 0);
            else if (p == 11) set_config(w, 1024, 512, 512, 128);
            else if (p == 6) set_config(2047, 2047, 2047, 1023, 131071);
            else set_config(w, is, os, $urandom_range(0, w / 2 + 3), $urandom_range(0, 131071));
            send_request(CMD_RESTART, 0);
            repeat (p == 6 ? 40 : 100) random_request();
            drain_results();
        end
        throttle = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_PUSH;
        s_sample = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        win_reg = WIN_RESET;
        ishift_reg = ISHIFT_RESET;
        oshift_reg = OSHIFT_RESET;
        fade_reg = FADE_RESET;
        step_reg = STEP_RESET;
        clear_stores();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_stream();
        test_frame_cycle();
        test_midstream_registers();
        test_random_streams();
        if (error_count == 0 && pending_results.size() == 0)
            $display("overlap_add_time_stretch_tb: clean");
        else
            $display("overlap_add_time_stretch_tb: errors");
        $finish;
    end

endmodule
